FILE: hw/rtl/urmf_pkg.sv
// Shared types and constants for the ultrasonic range median filter.
// No dependencies; every other file refers to this package by scoped names.
package urmf_pkg;

   // Field widths of the channels.
   localparam int MaskBits = 4;
   localparam int SlotW    = 2;
   localparam int WidthW   = 16;
   localparam int DistW    = 14;
   localparam int MaxW     = 16;
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 16;

   // Conversion and classification constants.
   localparam logic [WidthW-1:0] MinWidthUs   = 16'd150;
   localparam logic [MaxW-1:0]   MaxDistReset = 16'd4000;
   localparam int                MmNum        = 10;
   localparam int                MmDen        = 58;

   // width * 10 / 58 is computed as (width * DistRecip) >> DistShift. The
   // reciprocal is rounded up; over 16-bit widths the excess stays far below
   // one step of 1/58, so the floor is exact.
   localparam int                DistShift     = 24;
   localparam int                RecipW        = 22;
   localparam int                ProdW         = WidthW + RecipW;
   localparam logic [63:0]       DistRecipWide =
      ((64'(MmNum) << DistShift) + 64'(MmDen) - 64'd1) / 64'(MmDen);
   localparam logic [RecipW-1:0] DistRecip     = DistRecipWide[RecipW-1:0];

   typedef enum logic [CsrIdxW-1:0] {
      CSR_ACTIVE_MASK  = 2'd0,
      CSR_MAX_DISTANCE = 2'd1
   } csr_index_type;

   // A stored reading. Invalid readings carry a zero distance, so the packed
   // value orders exactly like the 0xFFFF invalid mark: above every distance.
   typedef struct packed {
      logic             invalid;
      logic [DistW-1:0] mm;
   } reading_type;

   localparam reading_type InvalidReading = '{invalid: 1'b1, mm: '0};

   // One classified item travelling from the front end to the filter.
   typedef struct packed {
      logic [SlotW-1:0] slot;
      reading_type      reading;
      logic [SlotW-1:0] next_slot;
   } job_type;

endpackage

FILE: hw/rtl/urmf_req_if.sv
// Input channel of the range filter: one echo width per beat.
// Depends on urmf_pkg for the field width.
interface urmf_req_if;
   logic                        valid;
   logic                        ready;
   logic [urmf_pkg::WidthW-1:0] echo_width_us;

   modport source (output valid, echo_width_us, input ready);
   modport sink (input valid, echo_width_us, output ready);
endinterface

FILE: hw/rtl/urmf_rsp_if.sv
// Result channel of the range filter: one filtered reading per beat.
// Depends on urmf_pkg for the field widths.
interface urmf_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [urmf_pkg::SlotW-1:0] sensor_slot;
   logic [urmf_pkg::DistW-1:0] range_mm;
   logic                       reading_valid;
   logic [urmf_pkg::SlotW-1:0] next_slot;

   modport source (output valid, sensor_slot, range_mm, reading_valid, next_slot,
                   input ready);
   modport sink (input valid, sensor_slot, range_mm, reading_valid, next_slot,
                 output ready);
endinterface

FILE: hw/rtl/urmf_csr_if.sv
// Register write channel of the range filter: index and data per beat.
// Depends on urmf_pkg for the field widths.
interface urmf_csr_if;
   logic                          valid;
   logic                          ready;
   logic [urmf_pkg::CsrIdxW-1:0]  index;
   logic [urmf_pkg::CsrDataW-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/urmf_front.sv
// Front end: register file, round-robin slot selection, distance conversion
// and validity classification. Depends on urmf_pkg, urmf_req_if, urmf_csr_if.
module urmf_front #(
   parameter int ACTIVE_SLOTS = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   urmf_req_if.sink                req_chan,
   urmf_csr_if.sink                csr_chan,
   output logic                    push_valid,
   output urmf_pkg::job_type       push_job,
   input  logic                    push_ready,
   output logic [ACTIVE_SLOTS-1:0] clear_slots
);

   localparam int CandW = urmf_pkg::SlotW + 1;
   localparam logic [urmf_pkg::MaskBits-1:0] SlotLimit =
      urmf_pkg::MaskBits'((1 << ACTIVE_SLOTS) - 1);

   logic [urmf_pkg::MaskBits-1:0] mask_ff, mask_in;
   logic [urmf_pkg::MaxW-1:0]     max_dist_ff, max_dist_in;
   logic [urmf_pkg::SlotW-1:0]    cur_ff, cur_in;
   logic                          s1_valid_ff, s1_valid_in;
   logic [urmf_pkg::SlotW-1:0]    s1_slot_ff, s1_slot_in;
   logic [urmf_pkg::SlotW-1:0]    s1_next_ff, s1_next_in;
   logic                          s1_wide_ff, s1_wide_in;
   logic [urmf_pkg::DistW-1:0]    s1_dist_ff, s1_dist_in;

   logic [urmf_pkg::MaskBits-1:0] active;
   logic                          any_active;
   logic [urmf_pkg::SlotW-1:0]    slot_sel;
   logic [urmf_pkg::SlotW-1:0]    next_sel;
   logic                          advance;
   logic                          csr_write;
   logic [urmf_pkg::ProdW-1:0]    product;
   logic                          reading_bad;

   // Next active slot strictly after the given one, wrapping. When the given
   // slot is the only active one it comes back as its own successor.
   function automatic logic [urmf_pkg::SlotW-1:0] next_of(
      input logic [urmf_pkg::SlotW-1:0]    from,
      input logic [urmf_pkg::MaskBits-1:0] act
   );
      logic [CandW-1:0]           cand;
      logic [urmf_pkg::SlotW-1:0] pick;
      pick = from;
      for (int k = ACTIVE_SLOTS; k >= 1; k--) begin
         cand = CandW'(from) + CandW'(k);
         if (cand >= CandW'(ACTIVE_SLOTS)) begin
            cand = cand - CandW'(ACTIVE_SLOTS);
         end
         if (act[cand[urmf_pkg::SlotW-1:0]]) begin
            pick = cand[urmf_pkg::SlotW-1:0];
         end
      end
      return pick;
   endfunction

   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid && csr_chan.ready;

   always_comb begin
      mask_in     = mask_ff;
      max_dist_in = max_dist_ff;
      clear_slots = '0;
      if (csr_write) begin
         unique case (csr_chan.index)
            urmf_pkg::CSR_ACTIVE_MASK: begin
               mask_in     = csr_chan.data[urmf_pkg::MaskBits-1:0];
               clear_slots = csr_chan.data[ACTIVE_SLOTS-1:0] & ~mask_ff[ACTIVE_SLOTS-1:0];
            end
            urmf_pkg::CSR_MAX_DISTANCE: begin
               max_dist_in = csr_chan.data[urmf_pkg::MaxW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Slots beyond the sensor count never take part.
   assign active     = mask_ff & SlotLimit;
   assign any_active = |active;
   assign slot_sel   = next_of(cur_ff, active);
   assign next_sel   = next_of(slot_sel, active);

   assign req_chan.ready = !s1_valid_ff || push_ready;
   assign advance        = req_chan.valid && req_chan.ready;

   assign product = urmf_pkg::ProdW'(req_chan.echo_width_us) *
                    urmf_pkg::ProdW'(urmf_pkg::DistRecip);

   // An item that finds no active slot is taken and dropped here.
   always_comb begin
      s1_valid_in = s1_valid_ff && !push_ready;
      s1_slot_in  = s1_slot_ff;
      s1_next_in  = s1_next_ff;
      s1_wide_in  = s1_wide_ff;
      s1_dist_in  = s1_dist_ff;
      cur_in      = cur_ff;
      if (advance) begin
         s1_valid_in = any_active;
         s1_slot_in  = slot_sel;
         s1_next_in  = next_sel;
         s1_wide_in  = req_chan.echo_width_us >= urmf_pkg::MinWidthUs;
         s1_dist_in  = product[urmf_pkg::DistShift +: urmf_pkg::DistW];
         if (any_active) begin
            cur_in = slot_sel;
         end
      end
   end

   assign reading_bad = !s1_wide_ff ||
                        (urmf_pkg::MaxW'(s1_dist_ff) >= max_dist_ff);

   always_comb begin
      push_valid             = s1_valid_ff;
      push_job.slot          = s1_slot_ff;
      push_job.next_slot     = s1_next_ff;
      push_job.reading       = '{invalid: 1'b0, mm: s1_dist_ff};
      if (reading_bad) begin
         push_job.reading = urmf_pkg::InvalidReading;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff     <= '0;
         max_dist_ff <= urmf_pkg::MaxDistReset;
         cur_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         mask_ff     <= mask_in;
         max_dist_ff <= max_dist_in;
         cur_ff      <= cur_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_slot_ff <= s1_slot_in;
      s1_next_ff <= s1_next_in;
      s1_wide_ff <= s1_wide_in;
      s1_dist_ff <= s1_dist_in;
   end

endmodule

FILE: hw/rtl/urmf_queue.sv
// Two-entry queue of classified items between the front end and the filter.
// Depends on urmf_pkg for the entry type.
module urmf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  urmf_pkg::job_type push_job,
   output logic              push_ready,
   output logic              pop_valid,
   output urmf_pkg::job_type pop_job,
   input  logic              pop_ready
);

   urmf_pkg::job_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push;
   logic              pop;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid  = count_ff != 2'd0;
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: hw/rtl/urmf_back.sv
// Back end: per-slot reading rings, median selection and the result register.
// Depends on urmf_pkg and urmf_rsp_if.
module urmf_back #(
   parameter int ACTIVE_SLOTS = 4,
   parameter int MEDIAN_DEPTH = 3
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pop_valid,
   input  urmf_pkg::job_type       pop_job,
   output logic                    pop_ready,
   input  logic [ACTIVE_SLOTS-1:0] clear_slots,
   urmf_rsp_if.source              rsp_chan
);

   localparam int IdxW = (ACTIVE_SLOTS > 1) ? $clog2(ACTIVE_SLOTS) : 1;
   localparam int PosW = (MEDIAN_DEPTH > 1) ? $clog2(MEDIAN_DEPTH) : 1;
   localparam int CntW = (MEDIAN_DEPTH > 1) ? $clog2(MEDIAN_DEPTH) : 1;
   localparam int Mid  = MEDIAN_DEPTH / 2;

   urmf_pkg::reading_type ring_ff [ACTIVE_SLOTS][MEDIAN_DEPTH];
   urmf_pkg::reading_type ring_in [ACTIVE_SLOTS][MEDIAN_DEPTH];
   logic [PosW-1:0]       pos_ff [ACTIVE_SLOTS];
   logic [PosW-1:0]       pos_in [ACTIVE_SLOTS];

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [urmf_pkg::SlotW-1:0] rsp_slot_ff, rsp_slot_in;
   logic [urmf_pkg::DistW-1:0] rsp_dist_ff, rsp_dist_in;
   logic                       rsp_good_ff, rsp_good_in;
   logic [urmf_pkg::SlotW-1:0] rsp_next_ff, rsp_next_in;

   logic                  pop;
   logic [IdxW-1:0]       idx;
   logic [PosW-1:0]       pos_cur;
   logic [PosW-1:0]       pos_adv;
   urmf_pkg::reading_type row [MEDIAN_DEPTH];
   urmf_pkg::reading_type median;
   logic [CntW-1:0]       rank;

   assign pop_ready = !rsp_valid_ff || rsp_chan.ready;
   assign pop       = pop_valid && pop_ready;
   assign idx       = pop_job.slot[IdxW-1:0];
   assign pos_cur   = pos_ff[idx];
   assign pos_adv   = (pos_cur == PosW'(MEDIAN_DEPTH - 1)) ? '0 : pos_cur + PosW'(1);

   // The row as it stands once the new reading is in place.
   always_comb begin
      for (int d = 0; d < MEDIAN_DEPTH; d++) begin
         row[d] = (pos_cur == PosW'(d)) ? pop_job.reading : ring_ff[idx][d];
      end
   end

   // Each entry's rank is the number of entries ahead of it in sorted order,
   // with equal values broken by position; the entry of middle rank wins.
   always_comb begin
      median = '0;
      rank   = '0;
      for (int i = 0; i < MEDIAN_DEPTH; i++) begin
         rank = '0;
         for (int j = 0; j < MEDIAN_DEPTH; j++) begin
            if (j != i) begin
               if ((row[j] < row[i]) || ((row[j] == row[i]) && (j < i))) begin
                  rank = rank + CntW'(1);
               end
            end
         end
         if (rank == CntW'(Mid)) begin
            median = row[i];
         end
      end
   end

   always_comb begin
      for (int s = 0; s < ACTIVE_SLOTS; s++) begin
         pos_in[s] = pos_ff[s];
         for (int d = 0; d < MEDIAN_DEPTH; d++) begin
            ring_in[s][d] = ring_ff[s][d];
         end
         if (clear_slots[s]) begin
            pos_in[s] = '0;
            for (int d = 0; d < MEDIAN_DEPTH; d++) begin
               ring_in[s][d] = urmf_pkg::InvalidReading;
            end
         end else if (pop && (idx == IdxW'(s))) begin
            pos_in[s] = pos_adv;
            for (int d = 0; d < MEDIAN_DEPTH; d++) begin
               ring_in[s][d] = row[d];
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_slot_in  = rsp_slot_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_good_in  = rsp_good_ff;
      rsp_next_in  = rsp_next_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
         rsp_slot_in  = pop_job.slot;
         rsp_dist_in  = median.mm;
         rsp_good_in  = !median.invalid;
         rsp_next_in  = pop_job.next_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < ACTIVE_SLOTS; s++) begin
            pos_ff[s] <= '0;
            for (int d = 0; d < MEDIAN_DEPTH; d++) begin
               ring_ff[s][d] <= urmf_pkg::InvalidReading;
            end
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         for (int s = 0; s < ACTIVE_SLOTS; s++) begin
            pos_ff[s] <= pos_in[s];
            for (int d = 0; d < MEDIAN_DEPTH; d++) begin
               ring_ff[s][d] <= ring_in[s][d];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_slot_ff <= rsp_slot_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_good_ff <= rsp_good_in;
      rsp_next_ff <= rsp_next_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.sensor_slot   = rsp_slot_ff;
   assign rsp_chan.range_mm      = rsp_dist_ff;
   assign rsp_chan.reading_valid = rsp_good_ff;
   assign rsp_chan.next_slot     = rsp_next_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_good_ff |-> rsp_dist_ff == '0)
      else $error("invalid median reported with a nonzero distance");

   assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid_ff && (rsp_slot_ff == $past(pop_job.slot)))
      else $error("dequeued item did not reach the result register");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> pos_cur <= PosW'(MEDIAN_DEPTH - 1))
      else $error("ring write position out of range");
`endif

endmodule

FILE: hw/rtl/ultrasonic_range_median_filter_core.sv
// Round-robin median-of-readings filter for up to four ultrasonic sensors.
//
// Channels: req_chan takes one echo width in microseconds per beat, rsp_chan
// returns the slot served, its median distance in millimetres, a valid flag
// and the next slot to fire. csr_chan writes register 0 (active slot mask,
// one bit per slot) and register 1 (maximum distance); other indexes are
// ignored. csr_chan is always ready and may be written only while no item
// is in flight. Setting a mask bit that was clear empties that slot's ring.
//
// Each accepted item advances to the next active slot. Its result is valid on
// rsp_chan once it has passed the front stage register and the queue into the
// result register; with no slot active the item is taken and dropped.
// With rsp_chan ready, the block sustains one item per cycle: the multiply
// stage, two-entry queue and result register each pass one beat per clock.
// When the receiver stalls, the result register holds and the queue fills;
// req_chan ready drops only once queue and front stage are both occupied.
//
// Synchronous reset clears all rings to invalid, the write positions and the
// slot pointer to zero, the mask to zero and the maximum distance to 4000.
// Depends on urmf_pkg, the channel interfaces, urmf_front, urmf_queue and
// urmf_back.
module ultrasonic_range_median_filter_core #(
   parameter int NUM_SENSORS  = 4,
   parameter int MEDIAN_DEPTH = 3
) (
   input  logic         clock,
   input  logic         reset,
   urmf_req_if.sink     req_chan,
   urmf_rsp_if.source   rsp_chan,
   urmf_csr_if.sink     csr_chan
);

   // Only the slots covered by the four-bit mask can ever take part.
   localparam int ActiveSlots = (NUM_SENSORS < urmf_pkg::MaskBits) ?
                                NUM_SENSORS : urmf_pkg::MaskBits;

   logic                   push_valid;
   urmf_pkg::job_type      push_job;
   logic                   push_ready;
   logic                   pop_valid;
   urmf_pkg::job_type      pop_job;
   logic                   pop_ready;
   logic [ActiveSlots-1:0] clear_slots;

   urmf_front #(
      .ACTIVE_SLOTS (ActiveSlots)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .csr_chan    (csr_chan),
      .push_valid  (push_valid),
      .push_job    (push_job),
      .push_ready  (push_ready),
      .clear_slots (clear_slots)
   );

   urmf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop_ready  (pop_ready)
   );

   urmf_back #(
      .ACTIVE_SLOTS (ActiveSlots),
      .MEDIAN_DEPTH (MEDIAN_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_job     (pop_job),
      .pop_ready   (pop_ready),
      .clear_slots (clear_slots),
      .rsp_chan    (rsp_chan)
   );

endmodule

FILE: tb/sv/ultrasonic_range_median_filter_core_tb.sv
// Self-checking testbench for the ultrasonic range median filter core.
// Depends on urmf_pkg, the three channel interfaces and the core itself.
`timescale 1ns / 1ps

module ultrasonic_range_median_filter_core_tb;

   localparam int NumSlots    = 4;
   localparam int RingDepth   = 3;
   localparam int SettleGap   = 8;
   localparam int LimitCycles = 400000;
   localparam int ReportCap   = 100;
   localparam int RandomItems = 1850;
   localparam int RandomPhases = 12;
   localparam int SpareBits   = urmf_pkg::CsrDataW - urmf_pkg::MaskBits;

   localparam logic [15:0]                  InvalidMark = 16'hFFFF;
   localparam logic [urmf_pkg::CsrIdxW-1:0] CsrSpareLo  = 2'd2;
   localparam logic [urmf_pkg::CsrIdxW-1:0] CsrSpareHi  = 2'd3;

   typedef struct packed {
      logic [urmf_pkg::SlotW-1:0] slot;
      logic [urmf_pkg::DistW-1:0] range_mm;
      logic                       ok;
      logic [urmf_pkg::SlotW-1:0] nxt;
   } filtered_reading_type;

   logic clock = 1'b0;
   logic reset;

   urmf_req_if req_bus ();
   urmf_rsp_if rsp_bus ();
   urmf_csr_if csr_bus ();

   ultrasonic_range_median_filter_core #(
      .NUM_SENSORS  (NumSlots),
      .MEDIAN_DEPTH (RingDepth)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predictor state, mirrors the block's registers and rings.
   logic [15:0]                   ring [NumSlots][RingDepth];
   int                            wr_pos [NumSlots];
   int                            served_slot;
   logic [urmf_pkg::MaskBits-1:0] live_mask;
   logic [urmf_pkg::MaxW-1:0]     max_dist;

   logic [urmf_pkg::WidthW-1:0]   pending_widths [$];
   filtered_reading_type          expected_readings [$];
   int                            send_idle_pct;
   int                            recv_stall_pct;
   int                            errors;
   int                            cycle_count;
   logic                          req_took;

   function automatic void clear_ring(input int s);
      for (int k = 0; k < RingDepth; k++) ring[s][k] = InvalidMark;
      wr_pos[s] = 0;
   endfunction

   function automatic void apply_register(input logic [urmf_pkg::CsrIdxW-1:0] idx,
                                          input logic [urmf_pkg::CsrDataW-1:0] value);
      logic [urmf_pkg::MaskBits-1:0] rising;
      if (idx == urmf_pkg::CSR_ACTIVE_MASK) begin
         // Only slots whose bit goes from clear to set start over.
         rising = value[urmf_pkg::MaskBits-1:0] & ~live_mask;
         for (int s = 0; s < NumSlots; s++)
            if (rising[s]) clear_ring(s);
         live_mask = value[urmf_pkg::MaskBits-1:0];
      end else if (idx == urmf_pkg::CSR_MAX_DISTANCE) begin
         max_dist = value[urmf_pkg::MaxW-1:0];
      end
   endfunction

   function automatic int next_live_slot(input int from);
      int s;
      for (int i = 1; i <= NumSlots; i++) begin
         s = (from + i) % NumSlots;
         if (live_mask[s]) return s;
      end
      return -1;
   endfunction

   function automatic void filter_echo(input logic [urmf_pkg::WidthW-1:0] width);
      int unsigned          mm;
      logic [15:0]          raw, lo, hi, c, med;
      int                   slot, nxt;
      filtered_reading_type r;
      slot = next_live_slot(served_slot);
      if (slot < 0) return;
      served_slot = slot;
      mm = 32'(width) * urmf_pkg::MmNum / urmf_pkg::MmDen;
      raw = (width >= urmf_pkg::MinWidthUs && mm < 32'(max_dist)) ? 16'(mm) : InvalidMark;
      ring[slot][wr_pos[slot]] = raw;
      wr_pos[slot] = (wr_pos[slot] + 1) % RingDepth;
      lo = (ring[slot][0] < ring[slot][1]) ? ring[slot][0] : ring[slot][1];
      hi = (ring[slot][0] < ring[slot][1]) ? ring[slot][1] : ring[slot][0];
      c = ring[slot][2];
      med = (c < lo) ? lo : ((c > hi) ? hi : c);
      nxt = next_live_slot(slot);
      if (nxt < 0) nxt = slot;
      r.slot     = urmf_pkg::SlotW'(slot);
      r.ok       = (med != InvalidMark);
      r.range_mm = r.ok ? med[urmf_pkg::DistW-1:0] : '0;
      r.nxt      = urmf_pkg::SlotW'(nxt);
      expected_readings.push_back(r);
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         errors++;
         if (errors <= ReportCap)
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   // Monitor: sample every handshake at the rising edge.
   always @(posedge clock) begin
      filtered_reading_type want;
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         req_took <= req_bus.valid && req_bus.ready;
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_readings.size() == 0) begin
               errors++;
               if (errors <= ReportCap)
                  $display("%0t ns: unexpected beat, expected none, got slot %0d range %0d",
                           $time, rsp_bus.sensor_slot, rsp_bus.range_mm);
            end else begin
               want = expected_readings.pop_front();
               check_field("sensor_slot", 16'(want.slot), 16'(rsp_bus.sensor_slot));
               check_field("range_mm", 16'(want.range_mm), 16'(rsp_bus.range_mm));
               check_field("reading_valid", 16'(want.ok), 16'(rsp_bus.reading_valid));
               check_field("next_slot", 16'(want.nxt), 16'(rsp_bus.next_slot));
            end
         end
         if (csr_bus.valid && csr_bus.ready) apply_register(csr_bus.index, csr_bus.data);
         if (req_bus.valid && req_bus.ready) filter_echo(req_bus.echo_width_us);
      end
   end

   // Driver: present the next echo width and the receiver's ready at the falling edge.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_bus.valid || req_took) begin
            if (pending_widths.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_bus.valid         <= 1'b1;
               req_bus.echo_width_us <= pending_widths.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LimitCycles) begin
         $display("ultrasonic_range_median_filter_core: mismatch");
         $finish;
      end
   end

   task automatic write_register(input logic [urmf_pkg::CsrIdxW-1:0] idx,
                                 input logic [urmf_pkg::CsrDataW-1:0] value);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = value;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Mask writes carry random upper data bits, which the block must ignore.
   task automatic write_mask(input logic [urmf_pkg::MaskBits-1:0] mask);
      write_register(urmf_pkg::CSR_ACTIVE_MASK,
                     {SpareBits'($urandom_range(16'hFFFF)), mask});
   endtask

   task automatic set_pace(input int mode);
      case (mode % 4)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
         default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
   endtask

   // Wait until every beat is out and every expectation met, then let the
   // pipeline settle, since dropped items leave no result to wait for.
   task automatic drain();
      while (pending_widths.size() != 0 || req_bus.valid || expected_readings.size() != 0)
         @(negedge clock);
      repeat (SettleGap) @(negedge clock);
   endtask

   function automatic logic [urmf_pkg::WidthW-1:0] random_width();
      int edge_us;
      case ($urandom_range(9)) inside
         [0:3]: return urmf_pkg::WidthW'($urandom_range(23200, 150));
         4: return urmf_pkg::WidthW'($urandom_range(149));
         [5:6]: return urmf_pkg::WidthW'($urandom_range(16'hFFFF));
         7: begin
            // Straddle the maximum distance threshold.
            edge_us = int'(max_dist) * urmf_pkg::MmDen / urmf_pkg::MmNum +
                      int'($urandom_range(12)) - 6;
            if (edge_us < 0) edge_us = 0;
            if (edge_us > 65535) edge_us = 65535;
            return urmf_pkg::WidthW'(edge_us);
         end
         8: begin
            case ($urandom_range(3))
               0: return 16'd0;
               1: return 16'd149;
               2: return 16'd150;
               default: return 16'hFFFF;
            endcase
         end
         default: return urmf_pkg::WidthW'($urandom_range(16'hFFFF, 23200));
      endcase
   endfunction

   initial begin
      logic [urmf_pkg::MaxW-1:0] max_pick;
      int                        per_phase;
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.echo_width_us = '0;
      rsp_bus.ready         = 1'b0;
      csr_bus.valid         = 1'b0;
      csr_bus.index         = '0;
      csr_bus.data          = '0;
      errors                = 0;
      cycle_count           = 0;
      for (int s = 0; s < NumSlots; s++) clear_ring(s);
      served_slot = 0;
      live_mask   = '0;
      max_dist    = urmf_pkg::MaxDistReset;
      set_pace(0);
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // No slot active: items are taken and dropped.
      pending_widths.push_back(16'd1000);
      pending_widths.push_back(16'hFFFF);
      drain();

      // One slot alone: it is also its own next slot. Width and threshold edges.
      write_mask(4'b0001);
      pending_widths.push_back(16'd0);
      pending_widths.push_back(16'd149);
      pending_widths.push_back(16'd150);
      pending_widths.push_back(16'd23194);
      pending_widths.push_back(16'd23200);
      pending_widths.push_back(16'hFFFF);
      drain();

      // All slots, then drop two and bring them back so their rings restart.
      write_mask(4'b1111);
      for (int i = 0; i < 4; i++)
         pending_widths.push_back(urmf_pkg::WidthW'(1000 + 2000 * i));
      drain();
      write_mask(4'b0101);
      pending_widths.push_back(16'd5000);
      pending_widths.push_back(16'd6000);
      drain();
      write_mask(4'b1111);
      for (int i = 0; i < 4; i++) pending_widths.push_back(16'd9000);
      drain();

      // Zero maximum rejects everything; the top maximum passes the widest echo.
      write_register(urmf_pkg::CSR_MAX_DISTANCE, 16'd0);
      pending_widths.push_back(16'd3000);
      pending_widths.push_back(16'd150);
      drain();
      write_register(urmf_pkg::CSR_MAX_DISTANCE, 16'hFFFF);
      write_register(CsrSpareLo, 16'h0000);
      write_register(CsrSpareHi, 16'hFFFF);
      pending_widths.push_back(16'hFFFF);
      pending_widths.push_back(16'hFFFF);
      drain();

      per_phase = RandomItems / RandomPhases;
      for (int p = 0; p < RandomPhases; p++) begin
         case ($urandom_range(5))
            0: max_pick = 16'd1;
            1: max_pick = 16'hFFFF;
            2: max_pick = urmf_pkg::MaxDistReset;
            3: max_pick = urmf_pkg::MaxW'($urandom_range(300, 2));
            default: max_pick = urmf_pkg::MaxW'($urandom_range(16'hFFFF, 1));
         endcase
         if (p == 3) max_pick = 16'd0;
         write_register(urmf_pkg::CSR_MAX_DISTANCE, max_pick);
         write_mask(p == 0 ? 4'b1111 : urmf_pkg::MaskBits'($urandom_range(15, 1)));
         set_pace(p);
         for (int i = 0; i < per_phase; i++) pending_widths.push_back(random_width());
         drain();
      end

      // A last burst with every slot turned off.
      write_mask(4'b0000);
      set_pace(3);
      for (int i = 0; i < 20; i++) pending_widths.push_back(random_width());
      drain();

      if (errors == 0) begin
         $display("ultrasonic_range_median_filter_core: match");
      end else begin
         $display("ultrasonic_range_median_filter_core: mismatch");
      end
      $finish;
   end

endmodule
